// File: design/arrl_pkg.sv
// Package for the address region registry lookup unit.
// Holds shared action codes, status codes, sizing constants and the queue item type.
package arrl_pkg;

    localparam int DefaultEntries = 16;
    localparam int QueueDepth     = 2;

    typedef enum logic [1:0] {
        ACT_REGISTER   = 2'd0,
        ACT_UNREGISTER = 2'd1,
        ACT_LOOKUP     = 2'd2,
        ACT_READ_TOTAL = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] key;
        logic [63:0] base;
        logic [63:0] size;
    } cmd_t;

endpackage

// File: design/arrl_front.sv
// Front end: accepts input items and classifies them into queued commands.
// A lookup item carries addr in base and length in size. Depends on arrl_pkg.
module arrl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    action,
    input  logic [63:0]   node_id,
    input  logic [63:0]   region_start,
    input  logic [63:0]   region_size,
    input  logic [63:0]   addr,
    input  logic [63:0]   length,
    output logic          cmd_valid,
    input  logic          cmd_take,
    output arrl_pkg::cmd_t cmd
);
    import arrl_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    cmd_t            q_mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;
    cmd_t            in_cmd;
    logic            push, pop;

    always_comb
    begin
        in_cmd.action = action_t'(action);
        in_cmd.key    = node_id;
        if (action_t'(action) == ACT_LOOKUP)
        begin
            in_cmd.base = addr;
            in_cmd.size = length;
        end
        else
        begin
            in_cmd.base = region_start;
            in_cmd.size = region_size;
        end
    end

    assign in_stall  = (count_reg == (PtrW+1)'(QueueDepth));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_valid && cmd_take;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/arrl_back.sv
// Back end: executes queued commands against the region table, one entry per cycle.
// Owns the table, the running total and the output register. Depends on arrl_pkg.
module arrl_back #(
    parameter int ENTRIES = arrl_pkg::DefaultEntries
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_take,
    input  arrl_pkg::cmd_t cmd,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     status,
    output logic [63:0]    match_node,
    output logic [63:0]    offset,
    output logic [63:0]    total_size
);
    import arrl_pkg::*;

    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_SUM,
        S_DONE
    } state_t;

    logic [63:0] key_mem  [ENTRIES];
    logic [63:0] base_mem [ENTRIES];
    logic [63:0] len_mem  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [IdxW-1:0] idx_reg;
    logic        hit_reg;
    logic [IdxW-1:0] hit_idx_reg;
    logic        free_reg;
    logic [IdxW-1:0] free_idx_reg;
    logic        best_reg;
    logic [63:0] best_key_reg;
    logic [63:0] best_off_reg;
    logic [63:0] total_reg;
    logic [63:0] acc_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [63:0] node_out_reg;
    logic [63:0] off_out_reg;
    logic [63:0] tot_out_reg;

    logic [63:0] e_key, e_base, e_len, diff;
    logic [64:0] span_end, acc_sum;
    logic        e_valid, contained, last;

    assign e_key     = key_mem[idx_reg];
    assign e_base    = base_mem[idx_reg];
    assign e_len     = len_mem[idx_reg];
    assign e_valid   = valid_reg[idx_reg];
    assign diff      = cmd_reg.base - e_base;
    assign span_end  = {1'b0, diff} + {1'b0, cmd_reg.size};
    assign contained = (cmd_reg.base >= e_base) && (span_end <= {1'b0, e_len});
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, e_len};
    assign last      = (idx_reg == IdxW'(ENTRIES - 1));

    assign cmd_take   = (state_reg == S_IDLE) && cmd_valid;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign match_node = node_out_reg;
    assign offset     = off_out_reg;
    assign total_size = tot_out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE && (hit_reg || free_reg) && cmd_reg.action == ACT_REGISTER)
        begin
            key_mem[hit_reg ? hit_idx_reg : free_idx_reg]  <= cmd_reg.key;
            base_mem[hit_reg ? hit_idx_reg : free_idx_reg] <= cmd_reg.base;
            len_mem[hit_reg ? hit_idx_reg : free_idx_reg]  <= cmd_reg.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            best_reg      <= 1'b0;
            best_key_reg  <= '0;
            best_off_reg  <= '0;
            acc_reg       <= '0;
            status_reg    <= ST_OK;
            node_out_reg  <= '0;
            off_out_reg   <= '0;
            tot_out_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        best_reg  <= 1'b0;
                        state_reg <= (cmd.action == ACT_READ_TOTAL) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (cmd_reg.action == ACT_LOOKUP)
                    begin
                        if (e_valid && contained && (!best_reg || e_key < best_key_reg))
                        begin
                            best_reg     <= 1'b1;
                            best_key_reg <= e_key;
                            best_off_reg <= diff;
                        end
                    end
                    else
                    begin
                        if (e_valid && e_key == cmd_reg.key && !hit_reg)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= idx_reg;
                        end
                        if (!e_valid && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= idx_reg;
                        end
                    end
                    if (last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (cmd_reg.action == ACT_LOOKUP) ? S_DONE : S_WRITE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_WRITE:
                begin
                    if (cmd_reg.action == ACT_REGISTER)
                    begin
                        if (hit_reg)
                        begin
                            valid_reg[hit_idx_reg] <= 1'b1;
                        end
                        else if (free_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                    end
                    else if (hit_reg)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    acc_reg   <= '0;
                    idx_reg   <= '0;
                    state_reg <= (cmd_reg.action == ACT_REGISTER && !hit_reg && !free_reg)
                                 ? S_DONE : S_SUM;
                end
                S_SUM:
                begin
                    if (e_valid)
                    begin
                        acc_reg <= acc_sum[64] ? '1 : acc_sum[63:0];
                    end
                    if (last)
                    begin
                        if (e_valid)
                        begin
                            total_reg <= acc_sum[64] ? '1 : acc_sum[63:0];
                        end
                        else
                        begin
                            total_reg <= acc_reg;
                        end
                        idx_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        tot_out_reg   <= total_reg;
                        status_reg    <= ST_OK;
                        node_out_reg  <= '0;
                        off_out_reg   <= '0;
                        if (cmd_reg.action == ACT_LOOKUP)
                        begin
                            if (best_reg)
                            begin
                                node_out_reg <= best_key_reg;
                                off_out_reg  <= best_off_reg;
                            end
                            else
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                        end
                        else if (cmd_reg.action == ACT_REGISTER && !hit_reg && !free_reg)
                        begin
                            status_reg <= ST_FULL;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/address_region_registry_lookup_unit.sv
// Flow: read total goes straight to the result. Lookup scans the table one entry per cycle.
// Register and unregister scan, write, then scan again to resum the total; a register into
// a full table skips the resum. The result then waits in the output register while stalled.
// Throughput: one item at a time in the back end; a two-item queue keeps input open while it has room.
// Reset: asynchronous active-low rst_n empties the table and the queue and zeroes the total.
// Depends on arrl_pkg, arrl_front and arrl_back.
module address_region_registry_lookup_unit #(
    parameter int ENTRIES = arrl_pkg::DefaultEntries
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] node_id,
    input  logic [63:0] region_start,
    input  logic [63:0] region_size,
    input  logic [63:0] addr,
    input  logic [63:0] length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] match_node,
    output logic [63:0] offset,
    output logic [63:0] total_size
);
    import arrl_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_take;

    arrl_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .node_id(node_id), .region_start(region_start),
        .region_size(region_size), .addr(addr), .length(length),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    arrl_back #(.ENTRIES(ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .match_node(match_node), .offset(offset),
        .total_size(total_size)
    );

endmodule

// File: tb/sv/tb_address_region_registry_lookup_unit.sv
`timescale 1ns / 100ps
// Testbench for the address region registry lookup unit: directed table, then random items.
// Checks results against a table predictor or fixed answers. Depends on arrl_pkg and the RTL.
module tb_address_region_registry_lookup_unit;
    import arrl_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_RANDOM = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        action_t     act;
        logic [63:0] key;
        logic [63:0] base;
        logic [63:0] size;
        logic [63:0] a;
        logic [63:0] len;
    } request_t;

    typedef struct {
        status_t     st;
        logic [63:0] node;
        logic [63:0] off;
        logic [63:0] total;
    } answer_t;

    typedef struct {
        request_t req;
        bit       typed;
        answer_t  ans;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [63:0] node_id;
    logic [63:0] region_start;
    logic [63:0] region_size;
    logic [63:0] addr;
    logic [63:0] length;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [63:0] match_node;
    logic [63:0] offset;
    logic [63:0] total_size;

    bit          region_used[NUM_ENTRIES];
    logic [63:0] region_key[NUM_ENTRIES];
    logic [63:0] region_base[NUM_ENTRIES];
    logic [63:0] region_len[NUM_ENTRIES];
    logic [63:0] region_total;

    answer_t     pending_answers[$];
    int          mismatches;
    int          idle_cycles;
    bit          quiet;
    bit          timed_out;
    logic [63:0] key_pool[8];

    address_region_registry_lookup_unit u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .node_id(node_id), .region_start(region_start),
        .region_size(region_size), .addr(addr), .length(length),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .match_node(match_node), .offset(offset), .total_size(total_size)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void sum_regions();
        logic [64:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (region_used[i]) begin
                acc = acc + {1'b0, region_len[i]};
                if (acc[64]) acc = {1'b0, MAX64};
            end
        end
        region_total = acc[63:0];
    endfunction

    function automatic int slot_of(logic [63:0] key);
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (region_used[i] && region_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic answer_t apply_request(request_t r);
        answer_t res;
        int slot;
        int best;
        logic [64:0] reach;
        res = '{ST_OK, 64'd0, 64'd0, 64'd0};
        case (r.act)
            ACT_REGISTER: begin
                slot = slot_of(r.key);
                if (slot < 0) begin
                    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
                        if (!region_used[i]) slot = i;
                    end
                end
                if (slot < 0) begin
                    res.st = ST_FULL;
                end else begin
                    region_used[slot] = 1'b1;
                    region_key[slot] = r.key;
                    region_base[slot] = r.base;
                    region_len[slot] = r.size;
                    sum_regions();
                end
            end
            ACT_UNREGISTER: begin
                slot = slot_of(r.key);
                if (slot >= 0) begin
                    region_used[slot] = 1'b0;
                    sum_regions();
                end
            end
            ACT_LOOKUP: begin
                best = -1;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (region_used[i] && r.a >= region_base[i]) begin
                        reach = {1'b0, r.a - region_base[i]} + {1'b0, r.len};
                        if (reach <= {1'b0, region_len[i]}) begin
                            if (best < 0 || region_key[i] < region_key[best]) best = i;
                        end
                    end
                end
                if (best < 0) begin
                    res.st = ST_NOT_FOUND;
                end else begin
                    res.node = region_key[best];
                    res.off = r.a - region_base[best];
                end
            end
            default: ;
        endcase
        res.total = region_total;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_addr(int sel);
        case (sel)
            0: return 64'd0;
            1: return MAX64;
            default: return rand64();
        endcase
    endfunction

    task automatic send_item(request_t r, bit typed, answer_t typed_ans);
        answer_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= r.act;
        node_id <= r.key;
        region_start <= r.base;
        region_size <= r.size;
        addr <= r.a;
        length <= r.len;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = apply_request(r);
        pending_answers.push_back(typed ? typed_ans : predicted);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk) begin
        answer_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: status %0d", status);
            end else begin
                e = pending_answers.pop_front();
                if (status !== e.st || match_node !== e.node || offset !== e.off
                    || total_size !== e.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp %0d %h %h %h, got %0d %h %h %h",
                                 e.st, e.node, e.off, e.total,
                                 status, match_node, offset, total_size);
                end
            end
        end
    end

    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                $display("** address_region_registry_lookup_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        table_row_t rows[$];
        request_t r;
        answer_t none;
        int sel;
        logic [63:0] b;
        logic [63:0] s;
        in_valid = 1'b0;
        action = ACT_READ_TOTAL;
        node_id = '0;
        region_start = '0;
        region_size = '0;
        addr = '0;
        length = '0;
        rst_n = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        timed_out = 1'b0;
        region_total = '0;
        none = '{ST_OK, 64'd0, 64'd0, 64'd0};
        for (int i = 0; i < NUM_ENTRIES; i++) region_used[i] = 1'b0;
        for (int i = 0; i < 8; i++) key_pool[i] = (i < 2) ? (i == 0 ? 64'd0 : MAX64) : rand64();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{'{ACT_READ_TOTAL, MAX64, MAX64, MAX64, MAX64, MAX64}, 1, none});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, 0, 0}, 1, '{ST_NOT_FOUND, 0, 0, 0}});
        rows.push_back('{'{ACT_UNREGISTER, 64'd5, 0, 0, 0, 0}, 1, none});
        rows.push_back('{'{ACT_REGISTER, 64'd0, 64'h1000, 64'h100, 0, 0}, 1,
                         '{ST_OK, 0, 0, 64'h100}});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, 64'h1000, 64'h100}, 1, '{ST_OK, 0, 0, 64'h100}});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, 64'h1100, 64'h0}, 0, none});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, 64'h1001, 64'h100}, 0, none});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, 64'hFFF, 64'h1}, 0, none});
        rows.push_back('{'{ACT_REGISTER, MAX64, 64'd0, MAX64, 0, 0}, 0, none});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, 64'h1010, 64'h10}, 0, none});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, MAX64, MAX64}, 0, none});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, 64'h8, MAX64}, 0, none});
        rows.push_back('{'{ACT_REGISTER, 64'd7, MAX64, 64'd1, 0, 0}, 0, none});
        rows.push_back('{'{ACT_LOOKUP, 0, 0, 0, MAX64, 64'd1}, 0, none});
        rows.push_back('{'{ACT_REGISTER, 64'd0, 64'h2000, 64'h20, 0, 0}, 0, none});
        for (int i = 1; i <= 14; i++)
            rows.push_back('{'{ACT_REGISTER, 64'(100 + i), 64'(i) << 40, 64'h10, 0, 0}, 0, none});
        rows.push_back('{'{ACT_UNREGISTER, 64'd103, 0, 0, 0, 0}, 0, none});
        rows.push_back('{'{ACT_REGISTER, 64'd200, 0, 64'd4, 0, 0}, 0, none});
        rows.push_back('{'{ACT_READ_TOTAL, 0, 0, 0, 0, 0}, 0, none});
        foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].ans);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 60) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_answers.size() != 0);
            end
            if (n == NUM_RANDOM - 80) quiet = 1'b1;
            if (n == 250 || n == 450) begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (region_used[i]) begin
                        r = '{ACT_UNREGISTER, region_key[i], 0, 0, 0, 0};
                        send_item(r, 0, none);
                    end
                end
            end
            r = '{action_t'($urandom_range(0, 3)), rand64(), rand64(), rand64(),
                  rand64(), rand64()};
            sel = $urandom_range(0, 9);
            if (r.act == ACT_REGISTER || r.act == ACT_UNREGISTER) begin
                if (sel < 7) r.key = key_pool[$urandom_range(0, 7)];
                if (sel < 6) begin
                    r.base = ($urandom_range(0, 3) == 0) ? pick_addr($urandom_range(0, 2))
                                                         : 64'($urandom_range(0, 4095));
                    r.size = ($urandom_range(0, 3) == 0) ? pick_addr($urandom_range(0, 2))
                                                         : 64'($urandom_range(0, 2048));
                end
            end else if (r.act == ACT_LOOKUP && sel < 8) begin
                b = 64'($urandom_range(0, 6000));
                s = 64'($urandom_range(0, 600));
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (region_used[i] && $urandom_range(0, 2) == 0) begin
                        b = region_base[i] + 64'($urandom_range(0, 40)) - 64'd4;
                        s = 64'($urandom_range(0, 300));
                    end
                end
                r.a = b;
                r.len = (sel == 0) ? MAX64 - b + 64'd1 : s;
            end
            send_item(r, 0, none);
        end
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (4 * NUM_ENTRIES + 20) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0 && !timed_out)
            $display("** address_region_registry_lookup_unit: PASSED **");
        else
            $display("** address_region_registry_lookup_unit: FAILED **");
        $finish;
    end
endmodule
